// File: rtl/sic_pkg.sv
// shared constants for the segment intersection classifier
`default_nettype none

package sic_pkg;

  localparam int RELATION_W = 2;

  // relation codes
  localparam logic [RELATION_W-1:0] REL_NONE     = 2'd0;
  localparam logic [RELATION_W-1:0] REL_CROSS    = 2'd1;
  localparam logic [RELATION_W-1:0] REL_TOUCH    = 2'd2;
  localparam logic [RELATION_W-1:0] REL_COLLINEAR = 2'd3;

  // output tdata is the relation code padded to one byte
  localparam int OUT_TDATA_W = 8;

endpackage

`default_nettype wire

// File: rtl/sic_prep.sv
// first stage: unpack coordinates, edge vectors, degenerate and betweenness flags
`default_nettype none

module sic_prep #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [8*COORD_WIDTH-1:0]       coords,
  output logic signed [COORD_WIDTH:0]         dcx,
  output logic signed [COORD_WIDTH:0]         dcy,
  output logic signed [COORD_WIDTH:0]         bax,
  output logic signed [COORD_WIDTH:0]         bay,
  output logic signed [COORD_WIDTH:0]         dax,
  output logic signed [COORD_WIDTH:0]         day,
  output logic signed [COORD_WIDTH:0]         cax,
  output logic signed [COORD_WIDTH:0]         cay,
  output logic                                degenerate,
  output logic                                endpoint_between
);

  localparam int CW = COORD_WIDTH;

  logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;

  assign ax = $signed(coords[0*CW +: CW]);
  assign ay = $signed(coords[1*CW +: CW]);
  assign bx = $signed(coords[2*CW +: CW]);
  assign by = $signed(coords[3*CW +: CW]);
  assign cx = $signed(coords[4*CW +: CW]);
  assign cy = $signed(coords[5*CW +: CW]);
  assign dx = $signed(coords[6*CW +: CW]);
  assign dy = $signed(coords[7*CW +: CW]);

  // r lies between p and q on x, or on y when p-q is vertical
  function automatic logic between(
    input logic signed [CW-1:0] px, input logic signed [CW-1:0] py,
    input logic signed [CW-1:0] qx, input logic signed [CW-1:0] qy,
    input logic signed [CW-1:0] rx, input logic signed [CW-1:0] ry
  );
    logic res;
    if (px != qx) begin
      res = ((px <= rx) && (rx <= qx)) || ((px >= rx) && (rx >= qx));
    end else begin
      res = ((py <= ry) && (ry <= qy)) || ((py >= ry) && (ry >= qy));
    end
    return res;
  endfunction

  function automatic logic signed [CW:0] diff(
    input logic signed [CW-1:0] u, input logic signed [CW-1:0] v
  );
    return $signed({u[CW-1], u}) - $signed({v[CW-1], v});
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      dcx <= diff(dx, cx);
      dcy <= diff(dy, cy);
      bax <= diff(bx, ax);
      bay <= diff(by, ay);
      dax <= diff(dx, ax);
      day <= diff(dy, ay);
      cax <= diff(cx, ax);
      cay <= diff(cy, ay);
      degenerate <= ((ax == bx) && (ay == by)) || ((cx == dx) && (cy == dy));
      endpoint_between <= between(ax, ay, bx, by, cx, cy) ||
                          between(ax, ay, bx, by, dx, dy) ||
                          between(cx, cy, dx, dy, ax, ay) ||
                          between(cx, cy, dx, dy, bx, by);
    end
  end

endmodule

`default_nettype wire

// File: rtl/sic_mult.sv
// second stage: the six products behind the three cross products
`default_nettype none

module sic_mult #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [COORD_WIDTH:0]       dcx,
  input  wire logic signed [COORD_WIDTH:0]       dcy,
  input  wire logic signed [COORD_WIDTH:0]       bax,
  input  wire logic signed [COORD_WIDTH:0]       bay,
  input  wire logic signed [COORD_WIDTH:0]       dax,
  input  wire logic signed [COORD_WIDTH:0]       day,
  input  wire logic signed [COORD_WIDTH:0]       cax,
  input  wire logic signed [COORD_WIDTH:0]       cay,
  input  wire logic                              degenerate_in,
  input  wire logic                              between_in,
  output logic signed [2*COORD_WIDTH+1:0]        den_p,
  output logic signed [2*COORD_WIDTH+1:0]        den_q,
  output logic signed [2*COORD_WIDTH+1:0]        ns_p,
  output logic signed [2*COORD_WIDTH+1:0]        ns_q,
  output logic signed [2*COORD_WIDTH+1:0]        nt_p,
  output logic signed [2*COORD_WIDTH+1:0]        nt_q,
  output logic                                   degenerate,
  output logic                                   endpoint_between
);

  always_ff @(posedge clk) begin
    if (en) begin
      den_p <= dcx * bay;
      den_q <= bax * dcy;
      ns_p  <= dax * cay;
      ns_q  <= cax * day;
      nt_p  <= bax * cay;
      nt_q  <= cax * bay;
      degenerate       <= degenerate_in;
      endpoint_between <= between_in;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sic_resolve.sv
// third and fourth stages: cross product differences, then ratio tests and code
`default_nettype none

module sic_resolve #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              en_diff,
  input  wire logic                              en_code,
  input  wire logic signed [2*COORD_WIDTH+1:0]   den_p,
  input  wire logic signed [2*COORD_WIDTH+1:0]   den_q,
  input  wire logic signed [2*COORD_WIDTH+1:0]   ns_p,
  input  wire logic signed [2*COORD_WIDTH+1:0]   ns_q,
  input  wire logic signed [2*COORD_WIDTH+1:0]   nt_p,
  input  wire logic signed [2*COORD_WIDTH+1:0]   nt_q,
  input  wire logic                              degenerate_in,
  input  wire logic                              between_in,
  output logic [sic_pkg::RELATION_W-1:0]         relation_code
);

  localparam int PW = 2 * COORD_WIDTH + 2;

  logic signed [PW:0] den, ns, nt;
  logic               degenerate, endpoint_between;

  function automatic logic signed [PW:0] sub(
    input logic signed [PW-1:0] u, input logic signed [PW-1:0] v
  );
    return $signed({u[PW-1], u}) - $signed({v[PW-1], v});
  endfunction

  always_ff @(posedge clk) begin
    if (en_diff) begin
      den <= sub(den_p, den_q);
      ns  <= sub(ns_p, ns_q);
      nt  <= sub(nt_p, nt_q);
      degenerate       <= degenerate_in;
      endpoint_between <= between_in;
    end
  end

  logic den_zero, den_neg;
  logic ns_pos, ns_neg, ns_lt, ns_gt;
  logic nt_pos, nt_neg, nt_lt, nt_gt;
  logic crossing, outside;
  logic [sic_pkg::RELATION_W-1:0] relation_code_next;

  always_comb begin
    den_zero = (den == '0);
    den_neg  = den[PW];
    ns_pos   = !ns[PW] && (ns != '0);
    ns_neg   = ns[PW];
    ns_lt    = ns < den;
    ns_gt    = ns > den;
    nt_pos   = !nt[PW] && (nt != '0);
    nt_neg   = nt[PW];
    nt_lt    = nt < den;
    nt_gt    = nt > den;
    // with a negative denominator the ratio tests flip direction
    if (den_neg) begin
      crossing = ns_neg && ns_gt && nt_neg && nt_gt;
      outside  = ns_pos || ns_lt || nt_pos || nt_lt;
    end else begin
      crossing = ns_pos && ns_lt && nt_pos && nt_lt;
      outside  = ns_neg || ns_gt || nt_neg || nt_gt;
    end
    if (den_zero) begin
      // parallel path, nt doubles as the collinearity cross product
      if (degenerate || (nt != '0) || !endpoint_between) begin
        relation_code_next = sic_pkg::REL_NONE;
      end else begin
        relation_code_next = sic_pkg::REL_COLLINEAR;
      end
    end else if (crossing) begin
      relation_code_next = sic_pkg::REL_CROSS;
    end else if (outside) begin
      relation_code_next = sic_pkg::REL_NONE;
    end else begin
      relation_code_next = sic_pkg::REL_TOUCH;
    end
  end

  always_ff @(posedge clk) begin
    if (en_code) begin
      relation_code <= relation_code_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/segment_intersection_classifier.sv
// top level: four-stage segment pair classifier with stream handshakes
// an input transaction passes the prep, multiply, difference and code registers in turn to reach the master side
// throughput: one transaction per cycle while the master side accepts results; every stage is fully pipelined
// each stage holds its item while the next stage cannot take it, so stalls lose nothing
// reset clears the stage valid bits only; the data registers are not reset
`default_nettype none

module segment_intersection_classifier #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y
  input  wire logic [8*COORD_WIDTH-1:0]           s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // relation_code, zero padded
  output logic [sic_pkg::OUT_TDATA_W-1:0]         m_tdata
);

  localparam int CW = COORD_WIDTH;
  localparam int PW = 2 * CW + 2;

  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4;

  assign r4 = !v4 || m_tready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign s_tready = r1;
  assign m_tvalid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= s_tvalid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  logic signed [CW:0] dcx, dcy, bax, bay, dax, day, cax, cay;
  logic               degen1, btw1, degen2, btw2;
  logic signed [PW-1:0] den_p, den_q, ns_p, ns_q, nt_p, nt_q;
  logic [sic_pkg::RELATION_W-1:0] relation_code;

  sic_prep #(.COORD_WIDTH(CW)) u_prep (
    .clk              (clk),
    .en               (r1),
    .coords           (s_tdata),
    .dcx              (dcx),
    .dcy              (dcy),
    .bax              (bax),
    .bay              (bay),
    .dax              (dax),
    .day              (day),
    .cax              (cax),
    .cay              (cay),
    .degenerate       (degen1),
    .endpoint_between (btw1)
  );

  sic_mult #(.COORD_WIDTH(CW)) u_mult (
    .clk              (clk),
    .en               (r2),
    .dcx              (dcx),
    .dcy              (dcy),
    .bax              (bax),
    .bay              (bay),
    .dax              (dax),
    .day              (day),
    .cax              (cax),
    .cay              (cay),
    .degenerate_in    (degen1),
    .between_in       (btw1),
    .den_p            (den_p),
    .den_q            (den_q),
    .ns_p             (ns_p),
    .ns_q             (ns_q),
    .nt_p             (nt_p),
    .nt_q             (nt_q),
    .degenerate       (degen2),
    .endpoint_between (btw2)
  );

  sic_resolve #(.COORD_WIDTH(CW)) u_resolve (
    .clk           (clk),
    .en_diff       (r3),
    .en_code       (r4),
    .den_p         (den_p),
    .den_q         (den_q),
    .ns_p          (ns_p),
    .ns_q          (ns_q),
    .nt_p          (nt_p),
    .nt_q          (nt_q),
    .degenerate_in (degen2),
    .between_in    (btw2),
    .relation_code (relation_code)
  );

  assign m_tdata = {{(sic_pkg::OUT_TDATA_W - sic_pkg::RELATION_W){1'b0}}, relation_code};

endmodule

`default_nettype wire
